// File: hdl/spcd_pkg.sv
// shared types, constants and codes of the sphere pair collision detector
`default_nettype none

package spcd_pkg;

  localparam int MAX_SPHERES_DEF = 64;
  localparam int COORD_BITS_DEF  = 32;

  localparam int POS_W       = 32;
  localparam int RAD_W       = 31;
  localparam int RSUM_W      = 32;
  localparam int IDX_OUT_W   = 6;
  localparam int TOTAL_W     = 11;
  localparam int IN_TDATA_W  = 128;
  localparam int OUT_TDATA_W = 24;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 11'd2047;

  localparam logic ACT_CLEAR   = 1'b0;
  localparam logic ACT_ADD     = 1'b1;
  localparam logic KIND_PAIR   = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_GAP,
    ST_SQ,
    ST_SUM,
    ST_CHECK,
    ST_REPORT
  } state_t;

  typedef struct packed {
    logic load;
    logic rd;
    logic gap;
    logic sq;
    logic sum;
    logic emit_pair;
    logic emit_report;
    logic next_j;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic hit;
    logic last_j;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// File: hdl/spcd_datapath.sv
// sphere store, gap and distance pipeline, counters and result register
`default_nettype none

module spcd_datapath #(
  parameter int MAX_SPHERES = spcd_pkg::MAX_SPHERES_DEF,
  parameter int COORD_BITS  = spcd_pkg::COORD_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tuser,
  input  wire logic [spcd_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  wire spcd_pkg::cmd_t                     cmd,
  output spcd_pkg::stat_t                         stat,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [spcd_pkg::OUT_TDATA_W-1:0]        out_tdata,
  output logic                                    out_tuser,
  output logic                                    out_tlast
);

  localparam int CW    = (COORD_BITS < spcd_pkg::POS_W) ? COORD_BITS : spcd_pkg::POS_W;
  localparam int IDX_W = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
  localparam int CNT_W = $clog2(MAX_SPHERES + 1);
  localparam int ENT_W = 3 * CW + spcd_pkg::RAD_W + 1;
  localparam int SQ_W  = 2 * CW;
  localparam int RS_W  = spcd_pkg::RSUM_W;
  localparam int ACC_W = 2 * RS_W + 2;
  localparam int PW    = spcd_pkg::POS_W;
  localparam int RW    = spcd_pkg::RAD_W;
  localparam int OW    = spcd_pkg::IDX_OUT_W;
  localparam int TW    = spcd_pkg::TOTAL_W;

  logic [CW-1:0] in_x, in_y, in_z;
  logic [RW-1:0] in_rad;
  logic          in_dyn;
  logic          wr_en;

  logic [ENT_W-1:0] store_r [MAX_SPHERES];
  logic [ENT_W-1:0] rd_q_r;

  logic [CNT_W-1:0] cnt_r, rep_idx_r, j_r;
  logic [TW-1:0]    total_r, total_inc;
  logic             rep_full_r;

  logic [CW-1:0] x_r, y_r, z_r;
  logic [RW-1:0] rad_r;
  logic          dyn_r;

  logic [CW-1:0] e_x, e_y, e_z;
  logic [RW-1:0] e_rad;
  logic          e_dyn;
  logic [CW:0]   dx, dy, dz;

  logic [CW-1:0]   gx_r, gy_r, gz_r;
  logic [RS_W-1:0] comb_r;
  logic            skip_r;
  logic [SQ_W-1:0] sqx_r, sqy_r, sqz_r;
  logic [2*RS_W-1:0] sqc_r;
  logic            axis_ok_r;
  logic [ACC_W-1:0] acc;
  logic            hit_r;

  logic                 out_valid_r;
  logic [spcd_pkg::OUT_TDATA_W-1:0] out_data_r;
  logic                 out_kind_r, out_last_r;

  // input word unpacking
  assign in_x   = in_tdata[CW-1:0];
  assign in_y   = in_tdata[PW+CW-1:PW];
  assign in_z   = in_tdata[2*PW+CW-1:2*PW];
  assign in_rad = in_tdata[3*PW+RW-1:3*PW];
  assign in_dyn = in_tdata[3*PW+RW];

  assign wr_en = cmd.load && (in_tuser == spcd_pkg::ACT_ADD) && !stat.full;

  // sphere store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[cnt_r[IDX_W-1:0]] <= {in_dyn, in_rad, in_z, in_y, in_x};
    end
    if (cmd.rd) begin
      rd_q_r <= store_r[j_r[IDX_W-1:0]];
    end
  end

  // counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      total_r <= '0;
    end else if (cmd.load) begin
      if (in_tuser == spcd_pkg::ACT_CLEAR) begin
        cnt_r   <= '0;
        total_r <= '0;
      end else if (!stat.full) begin
        cnt_r <= CNT_W'(cnt_r + 1'b1);
      end
    end else if (cmd.emit_pair) begin
      total_r <= total_inc;
    end
  end

  assign total_inc = (total_r == spcd_pkg::TOTAL_MAX) ? total_r : TW'(total_r + 1'b1);

  // latched item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r        <= in_x;
      y_r        <= in_y;
      z_r        <= in_z;
      rad_r      <= in_rad;
      dyn_r      <= in_dyn;
      j_r        <= '0;
      rep_full_r <= (in_tuser == spcd_pkg::ACT_ADD) && stat.full;
      rep_idx_r  <= ((in_tuser == spcd_pkg::ACT_ADD) && !stat.full) ? cnt_r : '0;
    end else if (cmd.next_j) begin
      j_r <= CNT_W'(j_r + 1'b1);
    end
  end

  // stored entry fields
  assign e_x   = rd_q_r[CW-1:0];
  assign e_y   = rd_q_r[2*CW-1:CW];
  assign e_z   = rd_q_r[3*CW-1:2*CW];
  assign e_rad = rd_q_r[3*CW+RW-1:3*CW];
  assign e_dyn = rd_q_r[ENT_W-1];

  assign dx = {x_r[CW-1], x_r} - {e_x[CW-1], e_x};
  assign dy = {y_r[CW-1], y_r} - {e_y[CW-1], e_y};
  assign dz = {z_r[CW-1], z_r} - {e_z[CW-1], e_z};

  // absolute gaps and summed radius
  always_ff @(posedge clk) begin
    if (cmd.gap) begin
      gx_r   <= dx[CW] ? CW'(-dx) : dx[CW-1:0];
      gy_r   <= dy[CW] ? CW'(-dy) : dy[CW-1:0];
      gz_r   <= dz[CW] ? CW'(-dz) : dz[CW-1:0];
      comb_r <= RS_W'(rad_r) + RS_W'(e_rad);
      skip_r <= !dyn_r && !e_dyn;
    end
  end

  // squares
  always_ff @(posedge clk) begin
    if (cmd.sq) begin
      sqx_r     <= gx_r * gx_r;
      sqy_r     <= gy_r * gy_r;
      sqz_r     <= gz_r * gz_r;
      sqc_r     <= comb_r * comb_r;
      axis_ok_r <= !skip_r && (RS_W'(gx_r) <= comb_r) && (RS_W'(gy_r) <= comb_r)
                   && (RS_W'(gz_r) <= comb_r);
    end
  end

  // any carry past the square width exceeds the radius square
  assign acc = ACC_W'(sqx_r) + ACC_W'(sqy_r) + ACC_W'(sqz_r);

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      hit_r <= axis_ok_r && (acc <= ACC_W'(sqc_r));
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_pair || cmd.emit_report) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_pair) begin
      out_data_r <= {1'b0, total_inc, OW'(rep_idx_r), OW'(j_r)};
      out_kind_r <= spcd_pkg::KIND_PAIR;
      out_last_r <= 1'b0;
    end else if (cmd.emit_report) begin
      out_data_r <= {rep_full_r, total_r, OW'(rep_idx_r), {OW{1'b0}}};
      out_kind_r <= spcd_pkg::KIND_REPORT;
      out_last_r <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  assign stat.full     = (cnt_r == CNT_W'(MAX_SPHERES));
  assign stat.empty    = (cnt_r == '0);
  assign stat.hit      = hit_r;
  assign stat.last_j   = (CNT_W'(j_r + 1'b1) == rep_idx_r);
  assign stat.out_free = !out_valid_r || out_tready;

endmodule

`default_nettype wire

// File: hdl/spcd_ctrl.sv
// controller that walks the stored spheres for each item
`default_nettype none

module spcd_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  input  wire logic            in_tuser,
  input  wire spcd_pkg::stat_t stat,
  output spcd_pkg::cmd_t       cmd
);

  spcd_pkg::state_t state_r, state_nxt;
  logic             accept;

  assign accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spcd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      spcd_pkg::ST_IDLE: begin
        if (accept) begin
          if ((in_tuser == spcd_pkg::ACT_CLEAR) || stat.full || stat.empty) begin
            state_nxt = spcd_pkg::ST_REPORT;
          end else begin
            state_nxt = spcd_pkg::ST_READ;
          end
        end
      end
      spcd_pkg::ST_READ:  state_nxt = spcd_pkg::ST_GAP;
      spcd_pkg::ST_GAP:   state_nxt = spcd_pkg::ST_SQ;
      spcd_pkg::ST_SQ:    state_nxt = spcd_pkg::ST_SUM;
      spcd_pkg::ST_SUM:   state_nxt = spcd_pkg::ST_CHECK;
      spcd_pkg::ST_CHECK: begin
        priority if (stat.hit && !stat.out_free) begin
          state_nxt = spcd_pkg::ST_CHECK;
        end else if (stat.last_j) begin
          state_nxt = spcd_pkg::ST_REPORT;
        end else begin
          state_nxt = spcd_pkg::ST_READ;
        end
      end
      spcd_pkg::ST_REPORT: begin
        if (stat.out_free) begin
          state_nxt = spcd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = spcd_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      spcd_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      spcd_pkg::ST_READ: cmd.rd  = 1'b1;
      spcd_pkg::ST_GAP:  cmd.gap = 1'b1;
      spcd_pkg::ST_SQ:   cmd.sq  = 1'b1;
      spcd_pkg::ST_SUM:  cmd.sum = 1'b1;
      spcd_pkg::ST_CHECK: begin
        cmd.emit_pair = stat.hit && stat.out_free;
        cmd.next_j    = (!stat.hit || stat.out_free) && !stat.last_j;
      end
      spcd_pkg::ST_REPORT: cmd.emit_report = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/sphere_pair_collision_detect_core.sv
// top level of the sphere pair collision detector
//
// Keeps up to MAX_SPHERES spheres of one frame. A clear word empties the store; an add word
// tests the new sphere against every stored sphere in index order, returns one pair word per
// collision and always ends with a report word (tlast high). A clear, a refused add or an add
// to an empty store goes straight to the report handshake. For an add with stored spheres
// the controller walks the store one entry at a time through the store read, the gap stage,
// the square stage, the sum-and-compare stage and the decision step, plus any stall on the
// result side. The next word is taken as soon as the report sits in the output register.
`default_nettype none

module sphere_pair_collision_detect_core #(
  parameter int MAX_SPHERES = spcd_pkg::MAX_SPHERES_DEF,
  parameter int COORD_BITS  = spcd_pkg::COORD_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // pos_x, pos_y, pos_z, radius, is_dynamic
  input  wire logic [spcd_pkg::IN_TDATA_W-1:0] in_tdata,
  // action
  input  wire logic                            in_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // earlier_index, new_index, collisions_total, table_full
  output logic [spcd_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // kind
  output logic                                 out_tuser,
  output logic                                 out_tlast
);

  spcd_pkg::cmd_t  cmd;
  spcd_pkg::stat_t stat;

  spcd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .stat      (stat),
    .cmd       (cmd)
  );

  spcd_datapath #(
    .MAX_SPHERES (MAX_SPHERES),
    .COORD_BITS  (COORD_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire
